// ===== rtl/rpkt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the relative position tracker.
package rpkt_pkg;

    localparam int unsigned WARMUP_FRAMES = 3;

    localparam logic [7:0] CFG_FPS  = 8'd0;
    localparam logic [7:0] CFG_QN   = 8'd1;
    localparam logic [7:0] CFG_RN   = 8'd2;
    localparam logic [7:0] CFG_P0   = 8'd3;

    localparam logic [9:0]  RST_FPS = 10'd30;
    localparam logic [30:0] RST_QN  = 31'd655;
    localparam logic [30:0] RST_RN  = 31'd655360;
    localparam logic [30:0] RST_P0  = 31'd6554;

    localparam logic signed [49:0] NUM_LIM = 50'sh0_7FFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        S_IDLE, S_FRONT, S_VELF, S_VELL, S_MAGV, S_SQV, S_SQVW, S_PRED,
        S_DET, S_DCHK, S_NODET, S_KMAC, S_KDIV, S_KDIVW, S_XUPD, S_PUPD,
        S_MAGD, S_SQD, S_SQDW, S_OUT
    } t_state;

    typedef struct packed {
        t_state     op;
        logic [4:0] idx;
        logic       step;
    } t_cmd;

    typedef struct packed {
        logic det_pos;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Q16.16 product rounded half up, floor after the shift
    function automatic logic signed [47:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t[63:16];
    endfunction

    function automatic logic [30:0] sat31(input logic [31:0] v);
        return v[31] ? 31'h7FFF_FFFF : v[30:0];
    endfunction

endpackage

// ===== rtl/relative_position_kalman_tracker_core.sv =====
// Top level of the relative position tracker with constant-velocity Kalman filter.
//
// Each input word is one camera frame's translation (forward, and a sideways
// component that is negated to form the lateral axis), Q16.16. The first three
// frames set the origin and report zero relative position, velocity and speed
// with origin_set low. After that the block reports origin minus current
// position, velocity as the change in relative position times frames_per_second,
// the speed magnitude, and the output of a 4-state Kalman filter (dt = 1,
// position measured) with its distance. All results saturate to 32 bits,
// speed and distance to 31. One word is worked at a time through a shared
// 32x32 multiplier, a one-bit-per-cycle divider and a one-bit-per-cycle
// square root unit. When the innovation determinant is not positive, the
// correction and its 8 gain divisions are skipped. A result held up by
// m_tready stalls the block at its last step. A finished result waits in the
// output register while the next word is
// accepted. Configuration: index 0 frames_per_second, 1 process_noise,
// 2 measurement_noise, 3 initial_error_cov; other indexes are dropped. Write
// configuration only while the block is idle. The error covariance is loaded
// from initial_error_cov on the first word after reset.
module relative_position_kalman_tracker_core
    import rpkt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] trans_forward, [63:32] trans_sideways
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] rel_forward, [63:32] rel_lateral, [95:64] vel_forward,
    // [127:96] vel_lateral, [158:128] speed, [190:159] filtered_forward,
    // [222:191] filtered_lateral, [253:223] filtered_distance, [255:254] zero
    output logic [255:0] m_tdata,
    output logic         m_tuser,   // [0] origin_set
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;
    logic  ready;
    logic  accept;

    assign s_tready    = ready;
    assign accept      = s_tvalid && ready;
    assign o_cfg_ready = 1'b1;

    rpkt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    rpkt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_accept    (accept),
        .i_in_data   (s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );
endmodule

// ===== rtl/rpkt_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
module rpkt_div
    import rpkt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_dividend,
    input  logic [47:0] i_divisor,
    output logic [62:0] o_quot,
    output logic        o_done
);
    logic [62:0] r_quot;
    logic [47:0] r_rem;
    logic [47:0] r_dsr;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] trial;
    logic        fits;

    assign trial = {r_rem, r_quot[62]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_cnt  <= 6'd63;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? 48'(trial - {1'b0, r_dsr}) : trial[47:0];
                r_quot <= {r_quot[61:0], fits};
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;
endmodule

// ===== rtl/rpkt_sqrt.sv =====
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
module rpkt_sqrt
    import rpkt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic [31:0] o_root,
    output logic        o_done
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] rb;

    assign rb = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_r    <= '0;
                r_b    <= 64'h4000_0000_0000_0000;
                r_cnt  <= '1;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= rb) begin
                    r_v <= r_v - rb;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b   <= r_b >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_r[31:0];
    assign o_done = r_done;
endmodule

// ===== rtl/rpkt_datapath.sv =====
// Datapath: state registers, shared multiplier and accumulator, divider and root units.
module rpkt_datapath
    import rpkt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic         i_accept,
    input  logic [63:0]  i_in_data,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_m_tready,
    output logic         o_m_tvalid,
    output logic [255:0] o_m_tdata,
    output logic         o_m_tuser
);
    logic [9:0]  r_fps;
    logic [30:0] r_qn, r_rn, r_p0;

    logic [1:0]         r_cnt;
    logic signed [31:0] r_in_f, r_in_s;
    logic signed [31:0] r_orig_f, r_orig_l, r_prev_f, r_prev_l;
    logic signed [31:0] r_rf, r_rl, r_vf, r_vl;
    logic signed [32:0] r_dvf, r_dvl;
    logic               r_live;
    logic [30:0]        r_speed;
    logic [30:0]        r_dist;

    logic signed [31:0] r_x  [4];
    logic signed [31:0] r_xp [4];
    logic signed [31:0] r_p  [16];
    logic signed [31:0] r_pp [16];
    logic signed [31:0] r_k  [8];

    logic signed [63:0] r_prod;
    logic signed [49:0] r_acc;
    logic signed [49:0] r_det;
    logic signed [49:0] r_num;
    logic [63:0]        r_sq;

    logic               r_out_valid;
    logic [255:0]       r_out_data;
    logic               r_out_user;

    logic signed [31:0] pa [16];
    logic signed [31:0] pn [16];
    logic signed [31:0] s00, s01, s10, s11;
    logic signed [31:0] y0, y1;
    logic signed [31:0] mul_a, mul_b;
    logic signed [49:0] base, term, n_acc;
    logic signed [47:0] rnd;
    logic               neg;
    logic               t;
    logic               live;
    logic signed [31:0] lat, rf, rl;
    logic               div_start, sqrt_start;
    logic [62:0]        div_quot, div_mag;
    logic               div_done, sqrt_done;
    logic [31:0]        sqrt_root;
    logic signed [31:0] k_new;
    logic               out_free;

    assign t        = i_cmd.idx[0];
    assign live     = 32'(r_cnt) >= WARMUP_FRAMES;
    assign out_free = !r_out_valid || i_m_tready;

    // Front end: lateral axis, relative position
    always_comb begin
        lat = sat32(-64'(r_in_s));
        rf  = sat32(64'(r_orig_f) - 64'(r_in_f));
        rl  = sat32(64'(r_orig_l) - 64'(lat));
    end

    // Predict: P' = F P F^T + Q
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            pa[j]      = sat32(64'(r_p[j]) + 64'(r_p[8 + j]));
            pa[4 + j]  = sat32(64'(r_p[4 + j]) + 64'(r_p[12 + j]));
            pa[8 + j]  = r_p[8 + j];
            pa[12 + j] = r_p[12 + j];
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                logic signed [63:0] c;
                c = (j < 2) ? 64'(pa[4*i + j]) + 64'(pa[4*i + j + 2]) : 64'(pa[4*i + j]);
                if (i == j) begin
                    c = c + 64'($signed({1'b0, r_qn}));
                end
                pn[4*i + j] = sat32(c);
            end
        end
    end

    assign s00 = sat32(64'(r_pp[0]) + 64'($signed({1'b0, r_rn})));
    assign s01 = r_pp[1];
    assign s10 = r_pp[4];
    assign s11 = sat32(64'(r_pp[5]) + 64'($signed({1'b0, r_rn})));
    assign y0  = sat32(64'(r_rf) - 64'(r_xp[0]));
    assign y1  = sat32(64'(r_rl) - 64'(r_xp[1]));

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        base  = '0;
        neg   = 1'b0;
        case (i_cmd.op)
            S_MAGV: begin
                mul_a = t ? r_vl : r_vf;
                mul_b = t ? r_vl : r_vf;
            end
            S_MAGD: begin
                mul_a = t ? r_x[1] : r_x[0];
                mul_b = t ? r_x[1] : r_x[0];
            end
            S_DET: begin
                mul_a = t ? s01 : s00;
                mul_b = t ? s10 : s11;
                neg   = t;
            end
            S_KMAC: begin
                neg = t;
                if (!i_cmd.idx[1]) begin
                    mul_a = r_pp[{i_cmd.idx[3:2], 1'b0, t}];
                    mul_b = t ? s10 : s11;
                end else begin
                    mul_a = r_pp[{i_cmd.idx[3:2], 1'b0, !t}];
                    mul_b = t ? s01 : s00;
                end
            end
            S_XUPD: begin
                mul_a = r_k[{i_cmd.idx[2:1], t}];
                mul_b = t ? y1 : y0;
                base  = 50'(r_xp[i_cmd.idx[2:1]]);
            end
            S_PUPD: begin
                mul_a = r_k[{i_cmd.idx[4:3], t}];
                mul_b = r_pp[{1'b0, t, i_cmd.idx[2:1]}];
                base  = 50'(r_pp[i_cmd.idx[4:1]]);
                neg   = 1'b1;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign rnd   = qround(r_prod);
    assign term  = neg ? -50'(rnd) : 50'(rnd);
    assign n_acc = (t ? r_acc : base) + term;

    assign div_start  = i_cmd.op == S_KDIV;
    assign sqrt_start = (i_cmd.op == S_SQV) || (i_cmd.op == S_SQD);
    assign div_mag    = {(r_num[49] ? 47'(-r_num) : 47'(r_num)), 16'd0};

    always_comb begin
        if (r_num[49]) begin
            k_new = (div_quot > 63'd2147483648) ? 32'sh8000_0000 : 32'(-div_quot[31:0]);
        end else begin
            k_new = (div_quot > 63'd2147483647) ? 32'sh7FFF_FFFF : div_quot[31:0];
        end
    end

    rpkt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (r_det[47:0]),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    rpkt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_sq),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_accept) begin
            r_in_f <= i_in_data[31:0];
            r_in_s <= i_in_data[63:32];
        end
        if (!i_rst_n) begin
            r_fps       <= RST_FPS;
            r_qn        <= RST_QN;
            r_rn        <= RST_RN;
            r_p0        <= RST_P0;
            r_cnt       <= '0;
            r_orig_f    <= '0;
            r_orig_l    <= '0;
            r_prev_f    <= '0;
            r_prev_l    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_x[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FPS: r_fps <= i_cfg_data[9:0];
                    CFG_QN:  r_qn  <= i_cfg_data[30:0];
                    CFG_RN:  r_rn  <= i_cfg_data[30:0];
                    CFG_P0:  r_p0  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // Load a new result word, or drop the old one once taken
            if (i_cmd.op == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                S_FRONT: begin
                    r_live <= live;
                    if (r_cnt == 2'd0) begin
                        for (int i = 0; i < 16; i++) begin
                            r_p[i] <= (i % 5 == 0) ? $signed({1'b0, r_p0}) : 32'sd0;
                        end
                    end
                    if (live) begin
                        r_rf     <= rf;
                        r_rl     <= rl;
                        r_dvf    <= 33'(rf) - 33'(r_prev_f);
                        r_dvl    <= 33'(rl) - 33'(r_prev_l);
                        r_prev_f <= rf;
                        r_prev_l <= rl;
                    end else begin
                        r_orig_f <= r_in_f;
                        r_orig_l <= lat;
                        r_cnt    <= r_cnt + 2'd1;
                        r_rf     <= '0;
                        r_rl     <= '0;
                        r_dvf    <= '0;
                        r_dvl    <= '0;
                        r_prev_f <= '0;
                        r_prev_l <= '0;
                    end
                end
                S_VELF: r_vf <= sat32(64'(r_dvf) * 64'($signed({1'b0, r_fps})));
                S_VELL: r_vl <= sat32(64'(r_dvl) * 64'($signed({1'b0, r_fps})));
                S_MAGV, S_MAGD: begin
                    if (i_cmd.step) begin
                        r_sq <= (t ? r_sq : 64'd0) + 64'(r_prod);
                    end
                end
                S_SQVW: if (sqrt_done) r_speed <= sat31(sqrt_root);
                S_PRED: begin
                    r_xp[0] <= sat32(64'(r_x[0]) + 64'(r_x[2]));
                    r_xp[1] <= sat32(64'(r_x[1]) + 64'(r_x[3]));
                    r_xp[2] <= r_x[2];
                    r_xp[3] <= r_x[3];
                    for (int i = 0; i < 16; i++) begin
                        r_pp[i] <= pn[i];
                    end
                end
                S_DET: begin
                    if (i_cmd.step) begin
                        r_acc <= n_acc;
                        if (t) r_det <= n_acc;
                    end
                end
                S_NODET: begin
                    for (int i = 0; i < 4; i++) r_x[i] <= r_xp[i];
                    for (int i = 0; i < 16; i++) r_p[i] <= r_pp[i];
                end
                S_KMAC: begin
                    if (i_cmd.step) begin
                        r_acc <= n_acc;
                        if (t) begin
                            r_num <= (n_acc > NUM_LIM) ? NUM_LIM
                                   : (n_acc < -NUM_LIM) ? -NUM_LIM : n_acc;
                        end
                    end
                end
                S_KDIVW: if (div_done) r_k[i_cmd.idx[3:1]] <= k_new;
                S_XUPD: begin
                    if (i_cmd.step) begin
                        r_acc <= n_acc;
                        if (t) r_x[i_cmd.idx[2:1]] <= sat32(64'(n_acc));
                    end
                end
                S_PUPD: begin
                    if (i_cmd.step) begin
                        r_acc <= n_acc;
                        if (t) r_p[i_cmd.idx[4:1]] <= sat32(64'(n_acc));
                    end
                end
                S_SQDW: begin
                    // Hold the distance until the result word is formed
                    if (sqrt_done) r_dist <= sat31(sqrt_root);
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_user          <= r_live;
                        r_out_data[31:0]    <= r_rf;
                        r_out_data[63:32]   <= r_rl;
                        r_out_data[95:64]   <= r_live ? r_vf : 32'sd0;
                        r_out_data[127:96]  <= r_live ? r_vl : 32'sd0;
                        r_out_data[158:128] <= r_live ? r_speed : 31'd0;
                        r_out_data[190:159] <= r_x[0];
                        r_out_data[222:191] <= r_x[1];
                        r_out_data[253:223] <= r_dist;
                        r_out_data[255:254] <= 2'b00;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.det_pos   = r_det > 50'sd0;
    assign o_stat.div_done  = div_done;
    assign o_stat.sqrt_done = sqrt_done;
    assign o_stat.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
endmodule

// ===== rtl/rpkt_ctrl.sv =====
// Sequencer: steps the datapath through front end, predict, gain, update and magnitudes.
module rpkt_ctrl
    import rpkt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);
    t_state     r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic       r_step, n_step;

    // Next state and term counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = 1'b0;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_FRONT;
            S_FRONT: n_state = S_VELF;
            S_VELF:  n_state = S_VELL;
            S_VELL: begin
                n_state = S_MAGV;
                n_idx   = '0;
            end
            S_MAGV, S_MAGD, S_DET, S_XUPD, S_PUPD, S_KMAC: begin
                n_step = !r_step;
                if (r_step) begin
                    n_idx = r_idx + 5'd1;
                    case (r_state)
                        S_MAGV: if (r_idx[0]) n_state = S_SQV;
                        S_MAGD: if (r_idx[0]) n_state = S_SQD;
                        S_DET:  if (r_idx[0]) n_state = S_DCHK;
                        S_XUPD: if (r_idx[2:0] == 3'd7) n_state = S_PUPD;
                        S_PUPD: if (r_idx == 5'd31) n_state = S_MAGD;
                        S_KMAC: begin
                            if (r_idx[0]) begin
                                n_state = S_KDIV;
                                n_idx   = r_idx;
                            end
                        end
                        default: ;
                    endcase
                    if (n_state != r_state && r_state != S_KMAC) begin
                        n_idx = '0;
                    end
                end
            end
            S_SQV:  n_state = S_SQVW;
            S_SQVW: if (i_stat.sqrt_done) n_state = S_PRED;
            S_PRED: begin
                n_state = S_DET;
                n_idx   = '0;
            end
            S_DCHK: begin
                n_idx   = '0;
                n_state = i_stat.det_pos ? S_KMAC : S_NODET;
            end
            S_NODET: n_state = S_MAGD;
            S_KDIV:  n_state = S_KDIVW;
            S_KDIVW: begin
                if (i_stat.div_done) begin
                    if (r_idx[3:0] == 4'd15) begin
                        n_state = S_XUPD;
                        n_idx   = '0;
                    end else begin
                        n_state = S_KMAC;
                        n_idx   = r_idx + 5'd1;
                    end
                end
            end
            S_SQD:  n_state = S_SQDW;
            S_SQDW: if (i_stat.sqrt_done) n_state = S_OUT;
            S_OUT:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.op   = r_state;
        o_cmd.idx  = r_idx;
        o_cmd.step = r_step;
        o_ready    = r_state == S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
        end
    end

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> r_state == S_IDLE)
        else $error("sequencer left idle without a word");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KDIVW && !i_stat.div_done) |=> (r_state == S_KDIVW && $stable(r_idx)))
        else $error("gain index moved during division");

    a_det_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DCHK) |=> ((r_state == S_KMAC) == $past(i_stat.det_pos)))
        else $error("correction branch does not follow determinant sign");

    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stat.out_free) |=> r_state == S_IDLE)
        else $error("result word not released to idle");
endmodule
